// File: hw/rtl/smgp_pkg.sv
package smgp_pkg;

  localparam int unsigned SampleW   = 24;
  localparam int unsigned MagW      = 24;
  localparam int unsigned RadW      = 2 * SampleW;
  localparam int unsigned IdxW      = 12;
  localparam int unsigned FlW       = 13;
  localparam int unsigned SrW       = 18;
  localparam int unsigned GateW     = 17;
  localparam int unsigned FreqW     = 25;
  localparam int unsigned CntW      = 6;
  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned CfgDataW  = 18;
  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 120;
  localparam int unsigned StoreDepth = 2049;
  localparam int unsigned MaxPeaks  = 63;
  localparam int unsigned MinFrame  = 8;
  localparam int unsigned MaxFrame  = 4096;
  localparam int unsigned DivW      = IdxW + SrW + 8;
  localparam int unsigned SqrtSteps = SampleW;
  localparam int unsigned IterW     = 6;

  // register indexes
  localparam logic [CfgAddrW-1:0] REG_FRAME_LENGTH  = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_SAMPLE_RATE   = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_GATE_FRACTION = 2'd2;

  // result kinds
  localparam logic KIND_PEAK    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic square;
    logic sqrt_init;
    logic sqrt_step;
    logic store;
    logic thr;
    logic rd;
    logic eval;
    logic mul;
    logic div_step;
    logic emit_peak;
    logic emit_sum;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_end;
    logic peak_emit;
    logic at_last;
    logic walk_done;
    logic out_free;
  } sts_t;

endpackage

// File: hw/rtl/spectrum_magnitude_gate_peaks_unit.sv
// Magnitude spectrum with noise gate and peak picking. Each input item is one
// complex bin; a frame has L/2+1 bins, L being frame_length clamped to 8..4096.
// A bin enters through the accept cycle, a squaring step, a root setup step, a
// 24-step square root unit with one result bit per cycle, and a store step.
// After the last bin the gate level is set, then the stored magnitudes are
// walked bin by bin, a read and then an evaluation per bin (one memory read
// port); each reported peak gets its frequency from a 38-step restoring divider.
// Peaks come out in rising index order, then a summary item with tlast set.
// Input is not taken while the frame's walk is running. The user must write
// configuration only while the block is idle; the block does not enforce it.
module spectrum_magnitude_gate_peaks_unit
  import smgp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  // bin_real[23:0], bin_imag[47:24]
  input  logic [InDataW-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // bin_index[11:0], frequency[36:12], magnitude[60:37], max_magnitude[84:61],
  // min_magnitude[108:85], peak_count[114:109], peak_overflow[115], zero pad
  output logic [OutDataW-1:0] out_tdata,
  // item_kind[0]
  output logic                out_tuser,
  output logic                out_tlast
);

  cmd_t cmd;
  sts_t sts;

  smgp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  smgp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// File: hw/rtl/smgp_ctrl.sv
module smgp_ctrl
  import smgp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_SQI  = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_UPD  = 4'd4;
  localparam logic [3:0] S_THR  = 4'd5;
  localparam logic [3:0] S_RD   = 4'd6;
  localparam logic [3:0] S_EV   = 4'd7;
  localparam logic [3:0] S_MUL  = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_PK   = 4'd10;
  localparam logic [3:0] S_SUMO = 4'd11;

  localparam logic [IterW-1:0] SqrtLast = IterW'(SqrtSteps - 1);
  localparam logic [IterW-1:0] DivLast  = IterW'(DivW - 1);

  logic [3:0]       state_r, state_nxt;
  logic [IterW-1:0] iter_r, iter_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_SQ;
        end
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = S_SQI;
      end
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        iter_nxt      = '0;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        iter_nxt      = iter_r + 1'b1;
        if (iter_r == SqrtLast) state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.store = 1'b1;
        state_nxt = sts.frame_end ? S_THR : S_IDLE;
      end
      S_THR: begin
        cmd.thr   = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EV;
      end
      S_EV: begin
        cmd.eval = 1'b1;
        if (sts.peak_emit) state_nxt = S_MUL;
        else if (sts.at_last) state_nxt = S_SUMO;
        else state_nxt = S_RD;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        iter_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        iter_nxt     = iter_r + 1'b1;
        if (iter_r == DivLast) state_nxt = S_PK;
      end
      S_PK: begin
        if (sts.out_free) begin
          cmd.emit_peak = 1'b1;
          state_nxt     = sts.walk_done ? S_SUMO : S_RD;
        end
      end
      S_SUMO: begin
        if (sts.out_free) begin
          cmd.emit_sum = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/smgp_dp.sv
module smgp_dp
  import smgp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic [InDataW-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tuser,
  output logic                out_tlast,
  input  cmd_t                cmd,
  output sts_t                sts
);

  // configuration
  logic [FlW-1:0]   frame_length_r;
  logic [SrW-1:0]   sample_rate_r;
  logic [GateW-1:0] gate_fraction_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r  <= FlW'(1024);
      sample_rate_r   <= SrW'(48000);
      gate_fraction_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_LENGTH:  frame_length_r  <= cfg_wdata[FlW-1:0];
        REG_SAMPLE_RATE:   sample_rate_r   <= cfg_wdata[SrW-1:0];
        REG_GATE_FRACTION: gate_fraction_r <= cfg_wdata[GateW-1:0];
        default: ;
      endcase
    end
  end

  // clamped frame length; last bin index is half of it
  logic [FlW-1:0]  fl_eff;
  logic [IdxW-1:0] last_idx;

  always_comb begin
    if (frame_length_r < FlW'(MinFrame)) fl_eff = FlW'(MinFrame);
    else if (frame_length_r > FlW'(MaxFrame)) fl_eff = FlW'(MaxFrame);
    else fl_eff = frame_length_r;
  end
  assign last_idx = fl_eff[FlW-1:1];

  // magnitude: abs, square, digit-by-digit root
  logic [SampleW-1:0] abs_re_r, abs_im_r;
  logic [RadW-1:0]    sq_re_r, sq_im_r, rad_r;
  logic [MagW-1:0]    root_r;
  logic [MagW+1:0]    rem_r;
  logic [MagW+3:0]    rem_sh, trial;
  logic [SampleW-1:0] in_re, in_im;

  assign in_re  = in_tdata[SampleW-1:0];
  assign in_im  = in_tdata[2*SampleW-1:SampleW];
  assign rem_sh = {rem_r, rad_r[RadW-1:RadW-2]};
  assign trial  = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      abs_re_r <= in_re[SampleW-1] ? (~in_re + 1'b1) : in_re;
      abs_im_r <= in_im[SampleW-1] ? (~in_im + 1'b1) : in_im;
    end
    if (cmd.square) begin
      sq_re_r <= abs_re_r * abs_re_r;
      sq_im_r <= abs_im_r * abs_im_r;
    end
    if (cmd.sqrt_init) begin
      rad_r  <= sq_re_r + sq_im_r;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r <= {rad_r[RadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= (MagW+2)'(rem_sh - trial);
        root_r <= {root_r[MagW-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[MagW+1:0];
        root_r <= {root_r[MagW-2:0], 1'b0};
      end
    end
  end

  // bin store, frame statistics
  logic [MagW-1:0] mem [StoreDepth];
  logic [MagW-1:0] rd_data_r;
  logic [IdxW-1:0] bin_cnt_r;
  logic [MagW-1:0] max_r, min_r;
  logic [IdxW-1:0] walk_r;

  assign sts.frame_end = (bin_cnt_r >= last_idx);

  always_ff @(posedge clk) begin
    if (cmd.store) mem[bin_cnt_r] <= root_r;
    if (cmd.rd)    rd_data_r <= mem[walk_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_cnt_r <= '0;
      max_r     <= '0;
      min_r     <= '0;
    end else if (cmd.store) begin
      bin_cnt_r <= sts.frame_end ? '0 : bin_cnt_r + 1'b1;
      if (bin_cnt_r == '0) begin
        max_r <= root_r;
        min_r <= root_r;
      end else begin
        if (root_r > max_r) max_r <= root_r;
        if (root_r < min_r) min_r <= root_r;
      end
    end
  end

  // gate and peak walk over the stored bins
  logic [MagW+GateW-1:0] thr_r;
  logic [MagW-1:0]       p2_r, p1_r, cur;
  logic [CntW-1:0]       count_r;
  logic                  ovf_r, done_r, peak_hit, full;
  logic [IdxW-1:0]       pk_idx_r;
  logic [MagW-1:0]       pk_mag_r;

  assign cur = ((MagW+GateW)'({rd_data_r, 16'h0}) < thr_r) ? '0 : rd_data_r;
  assign full = (count_r == CntW'(MaxPeaks));
  assign peak_hit = (walk_r >= IdxW'(2)) && (p1_r > p2_r) && (p1_r > cur);
  assign sts.peak_emit = peak_hit && !full;
  assign sts.at_last = (walk_r == last_idx);
  assign sts.walk_done = done_r;

  always_ff @(posedge clk) begin
    if (cmd.thr) thr_r <= max_r * gate_fraction_r;
    if (cmd.eval) begin
      p2_r     <= p1_r;
      p1_r     <= cur;
      pk_idx_r <= walk_r - 1'b1;
      pk_mag_r <= p1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r  <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
      done_r  <= 1'b0;
    end else if (cmd.thr) begin
      walk_r  <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      if (cmd.eval) begin
        walk_r <= walk_r + 1'b1;
        done_r <= sts.at_last;
        if (peak_hit && full) ovf_r <= 1'b1;
      end
      if (cmd.emit_peak) count_r <= count_r + 1'b1;
    end
  end

  // frequency: restoring divide of index * rate * 256 by frame length
  logic [DivW-1:0] q_r;
  logic [FlW-1:0]  drem_r;
  logic [FlW:0]    dtrial;

  assign dtrial = {drem_r, q_r[DivW-1]};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      q_r    <= {(IdxW+SrW)'(pk_idx_r * sample_rate_r), 8'h00};
      drem_r <= '0;
    end else if (cmd.div_step) begin
      if (dtrial >= {1'b0, fl_eff}) begin
        drem_r <= FlW'(dtrial - {1'b0, fl_eff});
        q_r    <= {q_r[DivW-2:0], 1'b1};
      end else begin
        drem_r <= dtrial[FlW-1:0];
        q_r    <= {q_r[DivW-2:0], 1'b0};
      end
    end
  end

  // result register
  logic                out_valid_r;
  logic [OutDataW-1:0] out_data_r;
  logic                out_kind_r;

  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_peak || cmd.emit_sum) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_peak) begin
      out_kind_r <= KIND_PEAK;
      out_data_r <= {4'h0, 1'b0, {CntW{1'b0}}, {MagW{1'b0}}, {MagW{1'b0}},
                     pk_mag_r, q_r[FreqW-1:0], pk_idx_r};
    end else if (cmd.emit_sum) begin
      out_kind_r <= KIND_SUMMARY;
      out_data_r <= {4'h0, ovf_r, count_r, min_r, max_r, {MagW{1'b0}},
                     {FreqW{1'b0}}, {IdxW{1'b0}}};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = (out_kind_r == KIND_SUMMARY);

endmodule

// File: verif/tb.sv
module tb;
  import smgp_pkg::*;

  localparam int unsigned WatchdogLimit = 400000;

  typedef struct {
    logic            kind;
    logic [IdxW-1:0] idx;
    logic [FreqW-1:0] freq;
    logic [MagW-1:0] mag;
    logic [MagW-1:0] mx;
    logic [MagW-1:0] mn;
    logic [CntW-1:0] cnt;
    logic            ovf;
    logic            lst;
  } peak_item_t;

  typedef struct {
    logic [SampleW-1:0] re;
    logic [SampleW-1:0] im;
    bit                 has_exp;
    logic [MagW-1:0]    exp_mag;
  } bin_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [InDataW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  spectrum_magnitude_gate_peaks_unit i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the block state
  logic [FlW-1:0]   sh_frame_len = 13'd1024;
  logic [SrW-1:0]   sh_rate = 18'd48000;
  logic [GateW-1:0] sh_gate = '0;
  logic [MagW-1:0]  mag_mem [StoreDepth];
  int unsigned      bin_cnt = 0;
  logic [MagW-1:0]  run_max = '0;
  logic [MagW-1:0]  run_min = '0;

  peak_item_t expected_items[$];
  int errors = 0;
  int idle_cycles = 0;
  bit out_hold = 1'b0;
  bit out_took = 1'b0;
  int rx_wait = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("tb: mismatch %s got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic logic [MagW-1:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[MagW-1:0];
  endfunction

  function automatic logic [63:0] abs_part(input logic [SampleW-1:0] x);
    return x[SampleW-1] ? 64'(-$signed({1'b1, x})) : 64'(x);
  endfunction

  function automatic logic [MagW-1:0] bin_magnitude(input logic [SampleW-1:0] re,
                                                   input logic [SampleW-1:0] im);
    logic [63:0] a;
    logic [63:0] b;
    a = abs_part(re);
    b = abs_part(im);
    return floor_sqrt(a * a + b * b);
  endfunction

  function automatic int unsigned eff_length();
    int unsigned fl;
    fl = sh_frame_len;
    if (fl < MinFrame) fl = MinFrame;
    if (fl > MaxFrame) fl = MaxFrame;
    return fl;
  endfunction

  // accumulate one bin; at frame end, gate and queue peaks plus summary
  task automatic predict_bin(input logic [SampleW-1:0] re, input logic [SampleW-1:0] im);
    int unsigned fl;
    int unsigned nb;
    logic [MagW-1:0] m;
    int unsigned count;
    bit ovf;
    peak_item_t it;
    fl = eff_length();
    nb = fl / 2 + 1;
    m = bin_magnitude(re, im);
    if (bin_cnt < StoreDepth) mag_mem[bin_cnt] = m;
    if (bin_cnt == 0) begin
      run_max = 0;
      run_min = m;
    end
    if (m > run_max) run_max = m;
    if (m < run_min) run_min = m;
    bin_cnt++;
    if (bin_cnt < nb) return;
    bin_cnt = 0;
    count = 0;
    ovf = 1'b0;
    for (int i = 0; i < nb; i++)
      if (64'(mag_mem[i]) * 65536 < 64'(run_max) * 64'(sh_gate)) mag_mem[i] = 0;
    for (int i = 1; i + 1 < nb; i++) begin
      if (mag_mem[i] > mag_mem[i-1] && mag_mem[i] > mag_mem[i+1]) begin
        if (count >= MaxPeaks) begin
          ovf = 1'b1;
        end else begin
          it = '{KIND_PEAK, IdxW'(i), FreqW'((64'(i) * 64'(sh_rate) * 256) / fl),
                 mag_mem[i], 0, 0, 0, 0, 0};
          expected_items.push_back(it);
          count++;
        end
      end
    end
    it = '{KIND_SUMMARY, 0, 0, 0, run_max, run_min, CntW'(count), ovf, 1'b1};
    expected_items.push_back(it);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] a, input logic [CfgDataW-1:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (a)
      REG_FRAME_LENGTH:  sh_frame_len = d[FlW-1:0];
      REG_SAMPLE_RATE:   sh_rate = d[SrW-1:0];
      REG_GATE_FRACTION: sh_gate = d[GateW-1:0];
      default: ;
    endcase
  endtask

  // send one bin, with a random gap first; returns at the falling edge after accept
  task automatic send_bin(input logic [SampleW-1:0] re, input logic [SampleW-1:0] im);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {im, re};
    do @(posedge clk); while (!in_tready);
    predict_bin(re, im);
    @(negedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_items.size() != 0 && guard < WatchdogLimit) begin
      @(posedge clk);
      guard++;
    end
    // the walk may still run after a frame with no result yet
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [SampleW-1:0] rand_part(input int scale);
    case (scale)
      0: return SampleW'($urandom);
      1: return SampleW'($signed($urandom_range(0, 2000)) - 1000);
      default: return SampleW'($urandom_range(0, 255));
    endcase
  endfunction

  // receiver: a random wait per item, long hold-off when requested
  always @(negedge clk) begin
    if (out_took) rx_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (out_hold) begin
      out_tready <= 1'b0;
    end else if (rx_wait != 0) begin
      out_tready <= 1'b0;
      rx_wait--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    peak_item_t w;
    out_took <= rst_n && out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_items.size() == 0) begin
        report_mismatch("unexpected item", out_tdata[IdxW-1:0], 0);
      end else begin
        w = expected_items.pop_front();
        if (out_tuser !== w.kind) report_mismatch("item_kind", out_tuser, w.kind);
        if (out_tdata[11:0] !== w.idx) report_mismatch("bin_index", out_tdata[11:0], w.idx);
        if (out_tdata[36:12] !== w.freq)
          report_mismatch("frequency", out_tdata[36:12], w.freq);
        if (out_tdata[60:37] !== w.mag) report_mismatch("magnitude", out_tdata[60:37], w.mag);
        if (out_tdata[84:61] !== w.mx)
          report_mismatch("max_magnitude", out_tdata[84:61], w.mx);
        if (out_tdata[108:85] !== w.mn)
          report_mismatch("min_magnitude", out_tdata[108:85], w.mn);
        if (out_tdata[114:109] !== w.cnt)
          report_mismatch("peak_count", out_tdata[114:109], w.cnt);
        if (out_tdata[115] !== w.ovf) report_mismatch("peak_overflow", out_tdata[115], w.ovf);
        if (out_tlast !== w.lst) report_mismatch("last", out_tlast, w.lst);
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n || cfg_we)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // directed frame at length 8: five bins, extremes and checked magnitudes
  bin_row_t dir_rows[] = '{
    '{24'h800000, 24'h800000, 1'b1, 24'd11863283},
    '{24'h7fffff, 24'h000000, 1'b1, 24'd8388607},
    '{24'h000000, 24'h000000, 1'b1, 24'd0},
    '{24'h000003, 24'hfffffc, 1'b1, 24'd5},
    '{24'h000000, 24'h000001, 1'b1, 24'd1},
    // second frame: a half gate leaves only the peak at 1
    '{24'd10, 24'd0, 1'b0, 0},
    '{24'd100, 24'd0, 1'b0, 0},
    '{24'd20, 24'd0, 1'b0, 0},
    '{24'd40, 24'd0, 1'b0, 0},
    '{24'd5, 24'd0, 1'b0, 0}
  };

  initial begin
    int nframes;
    int fl;
    int scale;
    for (int i = 0; i < StoreDepth; i++) mag_mem[i] = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // first frame runs with the reset rate and gate
    write_reg(REG_FRAME_LENGTH, 18'd8);
    foreach (dir_rows[r]) begin
      if (dir_rows[r].has_exp && bin_magnitude(dir_rows[r].re, dir_rows[r].im)
          !== dir_rows[r].exp_mag)
        report_mismatch("row magnitude", r, dir_rows[r].exp_mag);
      if (r == 5) begin
        drain();
        write_reg(REG_SAMPLE_RATE, 18'd192000);
        write_reg(REG_GATE_FRACTION, 18'd32768);
      end
      send_bin(dir_rows[r].re, dir_rows[r].im);
    end
    drain();

    // extremes: tiny length, zero rate, gate above one, odd length
    write_reg(REG_FRAME_LENGTH, 18'd3);
    write_reg(REG_SAMPLE_RATE, 18'd0);
    write_reg(REG_GATE_FRACTION, 18'd65536);
    for (int i = 0; i < 5; i++) send_bin(rand_part(0), rand_part(0));
    drain();
    write_reg(REG_FRAME_LENGTH, 18'd9);
    write_reg(REG_SAMPLE_RATE, 18'd262143);
    write_reg(REG_GATE_FRACTION, 18'd131071);
    for (int i = 0; i < 5; i++) send_bin(rand_part(0), rand_part(0));
    drain();

    // long receiver hold-off over three short frames: the block stalls its input
    write_reg(REG_FRAME_LENGTH, 18'd8);
    write_reg(REG_SAMPLE_RATE, 18'd44100);
    write_reg(REG_GATE_FRACTION, 18'd0);
    out_hold = 1'b1;
    fork
      begin
        for (int i = 0; i < 15; i++) send_bin(rand_part(1), rand_part(1));
      end
      begin
        repeat (1000) @(posedge clk);
        out_hold = 1'b0;
      end
    join
    drain();

    // overflow of peaks: alternating frame of 129 bins
    write_reg(REG_FRAME_LENGTH, 18'd256);
    for (int i = 0; i < 129; i++)
      send_bin((i % 2) ? 24'd500 + 24'($urandom_range(0, 9)) : 24'd3, rand_part(2));
    drain();

    // random frames at short lengths
    nframes = 0;
    while (nframes < 3) begin
      fl = $urandom_range(8, 20);
      write_reg(REG_FRAME_LENGTH, 18'(fl));
      write_reg(REG_SAMPLE_RATE, 18'($urandom_range(0, 192000)));
      write_reg(REG_GATE_FRACTION, 18'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 70000)));
      scale = $urandom_range(0, 2);
      for (int i = 0; i < eff_length() / 2 + 1; i++) send_bin(rand_part(scale), rand_part(scale));
      drain();
      nframes++;
    end
    if (errors == 0 && expected_items.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      if (expected_items.size() != 0) report_mismatch("left over", expected_items.size(), 0);
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
